@@ rtl/core/gsd_pkg.sv @@
package gsd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 10;
    localparam int KIND_W = 3;
    localparam int ORDER_W = 3;
    localparam int STATUS_W = 6;
    localparam int NUM_LEN = 5;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = LEN_W;
    localparam int MAX_SENTENCE_LEN_DEF = 1024;
    localparam int TEL_LEN = 3;

    localparam logic [REG_IDX_W-1:0] REG_START_BYTE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_END_BYTE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEN_F00 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LEN_F03 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LEN_F18 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEN_F22 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LEN_F23 = 3'd6;

    localparam logic [LEN_W-1:0] LEN_F00_RST = 10'd72;
    localparam logic [LEN_W-1:0] LEN_OTHER_RST = 10'd1;

    localparam logic [KIND_W-1:0] KIND_F00 = 3'd0;
    localparam logic [KIND_W-1:0] KIND_F03 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_F18 = 3'd2;
    localparam logic [KIND_W-1:0] KIND_F22 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_F23 = 3'd4;
    localparam logic [KIND_W-1:0] KIND_F99 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NONE = 3'd6;

    localparam logic [ORDER_W-1:0] ORDER_NONE = 3'd0;
    localparam logic [ORDER_W-1:0] ORDER_FIRST = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_ALL = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_MISSING_ALL = 6'h3E;
    localparam logic [STATUS_W-1:0] STATUS_MISSING_F00 = 6'h02;

    localparam logic [BYTE_W-1:0] CHAR_F = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_1 = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_2 = 8'h32;
    localparam logic [BYTE_W-1:0] CHAR_3 = 8'h33;
    localparam logic [BYTE_W-1:0] CHAR_8 = 8'h38;
    localparam logic [BYTE_W-1:0] CHAR_9 = 8'h39;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [NUM_LEN-1:0][LEN_W-1:0] len;
    } cfg_t;

    typedef struct packed {
        logic action;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic payload_valid;
        logic [KIND_W-1:0] sentence_kind;
        logic [LEN_W-1:0] payload_offset;
        logic [BYTE_W-1:0] payload_byte;
        logic sentence_done;
        logic checksum_ok;
        logic [STATUS_W-1:0] status_flags;
        logic [ORDER_W-1:0] order_stage;
        logic all_received;
        logic first_ready;
        logic set_ready;
    } result_t;

endpackage

@@ rtl/core/gsd_cfg.sv @@
module gsd_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gsd_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [gsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output gsd_pkg::cfg_t                     cfg
);

    gsd_pkg::cfg_t cfg_reg;
    gsd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                gsd_pkg::REG_START_BYTE: cfg_next.start_byte = cfg_data[gsd_pkg::BYTE_W-1:0];
                gsd_pkg::REG_END_BYTE:   cfg_next.end_byte = cfg_data[gsd_pkg::BYTE_W-1:0];
                gsd_pkg::REG_LEN_F00:    cfg_next.len[0] = cfg_data;
                gsd_pkg::REG_LEN_F03:    cfg_next.len[1] = cfg_data;
                gsd_pkg::REG_LEN_F18:    cfg_next.len[2] = cfg_data;
                gsd_pkg::REG_LEN_F22:    cfg_next.len[3] = cfg_data;
                gsd_pkg::REG_LEN_F23:    cfg_next.len[4] = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte <= '0;
            cfg_reg.end_byte <= '0;
            cfg_reg.len[0] <= gsd_pkg::LEN_F00_RST;
            cfg_reg.len[1] <= gsd_pkg::LEN_OTHER_RST;
            cfg_reg.len[2] <= gsd_pkg::LEN_OTHER_RST;
            cfg_reg.len[3] <= gsd_pkg::LEN_OTHER_RST;
            cfg_reg.len[4] <= gsd_pkg::LEN_OTHER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/gsd_parser.sv @@
module gsd_parser
#(
    parameter int MAX_SENTENCE_LEN = gsd_pkg::MAX_SENTENCE_LEN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  gsd_pkg::cfg_t       cfg,
    input  logic                step,
    input  gsd_pkg::item_t      item,
    output gsd_pkg::result_t    res
);

    localparam int CNT_BITS = $clog2(MAX_SENTENCE_LEN + 1);
    localparam int CNT_W = (CNT_BITS > gsd_pkg::LEN_W) ? CNT_BITS : gsd_pkg::LEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SENTENCE_LEN);
    localparam logic [CNT_W-1:0] CNT_TEL = CNT_W'(gsd_pkg::TEL_LEN);

    localparam logic [3:0] ST_WAIT = 4'd0;
    localparam logic [3:0] ST_ID1 = 4'd1;
    localparam logic [3:0] ST_ID2 = 4'd2;
    localparam logic [3:0] ST_ID3 = 4'd3;
    localparam logic [3:0] ST_PAY = 4'd4;
    localparam logic [3:0] ST_TEL = 4'd5;
    localparam logic [3:0] ST_CHKA = 4'd6;
    localparam logic [3:0] ST_CHKB = 4'd7;
    localparam logic [3:0] ST_DONE_OK = 4'd8;
    localparam logic [3:0] ST_DONE_BAD = 4'd9;

    function automatic logic [gsd_pkg::KIND_W-1:0] kind_of(
        input logic [gsd_pkg::BYTE_W-1:0] d1,
        input logic [gsd_pkg::BYTE_W-1:0] d2
    );
        logic [gsd_pkg::KIND_W-1:0] k;
        begin
            k = gsd_pkg::KIND_NONE;
            if (d1 == gsd_pkg::CHAR_0 && d2 == gsd_pkg::CHAR_0) k = gsd_pkg::KIND_F00;
            if (d1 == gsd_pkg::CHAR_0 && d2 == gsd_pkg::CHAR_3) k = gsd_pkg::KIND_F03;
            if (d1 == gsd_pkg::CHAR_1 && d2 == gsd_pkg::CHAR_8) k = gsd_pkg::KIND_F18;
            if (d1 == gsd_pkg::CHAR_2 && d2 == gsd_pkg::CHAR_2) k = gsd_pkg::KIND_F22;
            if (d1 == gsd_pkg::CHAR_2 && d2 == gsd_pkg::CHAR_3) k = gsd_pkg::KIND_F23;
            if (d1 == gsd_pkg::CHAR_9 && d2 == gsd_pkg::CHAR_9) k = gsd_pkg::KIND_F99;
            return k;
        end
    endfunction

    logic [3:0]                       state_reg, state_next;
    logic [gsd_pkg::BYTE_W-1:0]       digit_reg, digit_next;
    logic [gsd_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [2*gsd_pkg::BYTE_W-1:0]     xor_reg, xor_next;
    logic [gsd_pkg::BYTE_W-1:0]       chk_reg, chk_next;
    logic [gsd_pkg::ORDER_W-1:0]      order_reg, order_next;
    logic [gsd_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [1:0]                       ready_reg, ready_next;

    logic [gsd_pkg::BYTE_W-1:0]       b;
    logic [CNT_W-1:0]                 cnt_inc;
    logic [gsd_pkg::LEN_W-1:0]        len_sel;
    logic [2*gsd_pkg::BYTE_W-1:0]     lanes_base;
    logic                             chk_match;

    assign b = item.rx_byte;
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign lanes_base = (cnt_reg == '0) ? '0 : xor_reg;
    assign chk_match = (chk_reg == xor_reg[gsd_pkg::BYTE_W-1:0])
                    && (b == xor_reg[2*gsd_pkg::BYTE_W-1:gsd_pkg::BYTE_W]);

    always_comb
    begin
        case (kind_reg)
            gsd_pkg::KIND_F00: len_sel = cfg.len[0];
            gsd_pkg::KIND_F03: len_sel = cfg.len[1];
            gsd_pkg::KIND_F18: len_sel = cfg.len[2];
            gsd_pkg::KIND_F22: len_sel = cfg.len[3];
            gsd_pkg::KIND_F23: len_sel = cfg.len[4];
            default:           len_sel = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        digit_next = digit_reg;
        kind_next = kind_reg;
        cnt_next = cnt_reg;
        xor_next = xor_reg;
        chk_next = chk_reg;
        order_next = order_reg;
        status_next = status_reg;
        ready_next = ready_reg;
        res = '0;
        res.checksum_ok = 1'b1;

        if (item.action)
        begin
            status_next = status_reg | gsd_pkg::STATUS_MISSING_ALL;
            ready_next[0] = 1'b0;
        end
        else
        begin
            unique case (state_reg) inside
                ST_WAIT:
                begin
                    if (b == cfg.start_byte)
                    begin
                        ready_next[1] = 1'b0;
                        state_next = ST_ID1;
                        status_next[0] = 1'b0;
                    end
                    else
                    begin
                        status_next[0] = 1'b1;
                    end
                end
                ST_ID1:
                begin
                    if (b == gsd_pkg::CHAR_F)
                    begin
                        state_next = ST_ID2;
                        status_next[0] = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                        status_next[0] = 1'b1;
                    end
                end
                ST_ID2:
                begin
                    if (b == gsd_pkg::CHAR_0 || b == gsd_pkg::CHAR_1
                        || b == gsd_pkg::CHAR_2 || b == gsd_pkg::CHAR_9)
                    begin
                        digit_next = b;
                        state_next = ST_ID3;
                        status_next[0] = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                        status_next[0] = 1'b1;
                    end
                end
                ST_ID3:
                begin
                    kind_next = kind_of(digit_reg, b);
                    cnt_next = '0;
                    status_next[0] = 1'b0;
                    if (kind_next == gsd_pkg::KIND_NONE)
                    begin
                        state_next = ST_WAIT;
                        status_next[0] = 1'b1;
                    end
                    else if (kind_next == gsd_pkg::KIND_F99)
                    begin
                        state_next = ST_TEL;
                    end
                    else
                    begin
                        state_next = ST_PAY;
                    end
                end
                ST_PAY:
                begin
                    if (kind_reg > gsd_pkg::KIND_F23)
                    begin
                        state_next = ST_WAIT;
                        status_next[0] = 1'b1;
                    end
                    else
                    begin
                        xor_next = lanes_base;
                        if (cnt_reg[0])
                        begin
                            xor_next[2*gsd_pkg::BYTE_W-1:gsd_pkg::BYTE_W] =
                                lanes_base[2*gsd_pkg::BYTE_W-1:gsd_pkg::BYTE_W] ^ b;
                        end
                        else
                        begin
                            xor_next[gsd_pkg::BYTE_W-1:0] =
                                lanes_base[gsd_pkg::BYTE_W-1:0] ^ b;
                        end
                        res.payload_valid = 1'b1;
                        res.sentence_kind = kind_reg;
                        res.payload_offset = cnt_reg[gsd_pkg::LEN_W-1:0];
                        res.payload_byte = b;
                        cnt_next = cnt_inc;
                        if (cnt_inc == CNT_W'(len_sel) || cnt_inc >= CNT_MAX)
                        begin
                            cnt_next = '0;
                            state_next = ST_CHKA;
                        end
                    end
                end
                ST_TEL:
                begin
                    res.payload_valid = 1'b1;
                    res.sentence_kind = gsd_pkg::KIND_F99;
                    res.payload_offset = cnt_reg[gsd_pkg::LEN_W-1:0];
                    res.payload_byte = b;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= CNT_TEL)
                    begin
                        cnt_next = '0;
                        state_next = ST_DONE_OK;
                    end
                end
                ST_CHKA:
                begin
                    chk_next = b;
                    state_next = ST_CHKB;
                end
                ST_CHKB:
                begin
                    res.checksum_ok = chk_match;
                    state_next = chk_match ? ST_DONE_OK : ST_DONE_BAD;
                end
                ST_DONE_OK, ST_DONE_BAD:
                begin
                    res.checksum_ok = (state_reg == ST_DONE_OK);
                    if (b != cfg.end_byte || kind_reg > gsd_pkg::KIND_F99)
                    begin
                        state_next = ST_WAIT;
                        status_next[0] = 1'b1;
                    end
                    else
                    begin
                        if (kind_reg == gsd_pkg::KIND_F00)
                        begin
                            order_next = gsd_pkg::ORDER_FIRST;
                            ready_next[0] = 1'b1;
                        end
                        else if (kind_reg <= gsd_pkg::KIND_F23)
                        begin
                            if (order_reg == kind_reg)
                            begin
                                order_next = kind_reg + 3'd1;
                            end
                            if (kind_reg == gsd_pkg::KIND_F23)
                            begin
                                ready_next[1] = 1'b1;
                            end
                        end
                        if (kind_reg <= gsd_pkg::KIND_F23)
                        begin
                            status_next = status_next
                                & ~(gsd_pkg::STATUS_MISSING_F00 << kind_reg);
                        end
                        state_next = ST_WAIT;
                        status_next[0] = 1'b0;
                        res.sentence_done = 1'b1;
                    end
                end
                default:
                begin
                    state_next = ST_WAIT;
                    status_next[0] = 1'b1;
                end
            endcase
        end

        res.status_flags = status_next;
        res.order_stage = order_next;
        res.all_received = (order_next == gsd_pkg::ORDER_ALL);
        res.first_ready = ready_next[0];
        res.set_ready = ready_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            digit_reg <= '0;
            kind_reg <= gsd_pkg::KIND_F00;
            cnt_reg <= '0;
            xor_reg <= '0;
            chk_reg <= '0;
            order_reg <= gsd_pkg::ORDER_NONE;
            status_reg <= '0;
            ready_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            digit_reg <= digit_next;
            kind_reg <= kind_next;
            cnt_reg <= cnt_next;
            xor_reg <= xor_next;
            chk_reg <= chk_next;
            order_reg <= order_next;
            status_reg <= status_next;
            ready_reg <= ready_next;
        end
    end

endmodule

@@ rtl/core/gps_sentence_deframer.sv @@
// Sentence deframer for a receiver byte stream.
// The slave stream carries one received byte per word in s_tdata, with
// s_tuser set to request a rearm instead of a byte. The master stream
// returns exactly one result word for every accepted input word: a payload
// or telemetry byte with its kind and offset, the checksum verdict, the
// sentence-done mark on m_tlast, and the current status, order and ready
// flags. The configuration channel writes the start and end bytes and the
// five payload lengths; it is always ready and should be used only while
// no words are in flight.
// An accepted word is captured in the input register and parsed there; its
// result is loaded into the output register, which drives m_tvalid, when
// that register is empty or m_tready is high. One word per cycle is
// sustained while the receiver keeps m_tready high.
// When the receiver stalls, the output register holds its word and the
// input register fills; s_tready then drops until m_tready returns.
// Reset clears the valid flags of both registers (not their data), the parser
// state and flags, and loads the default configuration.
module gps_sentence_deframer
#(
    parameter int MAX_SENTENCE_LEN = gsd_pkg::MAX_SENTENCE_LEN_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] rx_byte
    input  logic                              s_tuser,  // [0] action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] payload_offset, [17:10] payload_byte, [18] checksum_ok,
    // [24:19] status_flags, [27:25] order_stage, [28] all_received,
    // [29] first_ready, [30] set_ready, [31] zero
    output logic [31:0]                       m_tdata,
    output logic [3:0]                        m_tuser,  // [0] payload_valid, [3:1] sentence_kind
    output logic                              m_tlast,  // sentence_done
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gsd_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [gsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    gsd_pkg::cfg_t    cfg;
    gsd_pkg::item_t   in_reg;
    gsd_pkg::result_t res;
    gsd_pkg::result_t out_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             step;

    assign advance = !out_valid_reg || m_tready;
    assign step = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    gsd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gsd_parser
    #(
        .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN)
    )
    u_parser
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .item  (in_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.action <= s_tuser;
            in_reg.rx_byte <= s_tdata;
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast = out_reg.sentence_done;
    assign m_tuser = {out_reg.sentence_kind, out_reg.payload_valid};
    assign m_tdata = {1'b0, out_reg.set_ready, out_reg.first_ready, out_reg.all_received,
                      out_reg.order_stage, out_reg.status_flags, out_reg.checksum_ok,
                      out_reg.payload_byte, out_reg.payload_offset};

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input not ready while output register is empty");

    a_all_received: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.all_received == (out_reg.order_stage == gsd_pkg::ORDER_ALL)))
        else $error("all_received disagrees with order stage");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.payload_valid) |->
            (out_reg.sentence_kind == '0 && out_reg.payload_offset == '0
             && out_reg.payload_byte == '0))
        else $error("payload fields not zero on a non-payload word");

    a_done_not_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.sentence_done && out_reg.payload_valid))
        else $error("sentence done and payload on the same word");

endmodule
